/* design/hrp_pkg.sv */
// ---------------------------------------------------------------------------
// hrp_pkg - handshake reply parser shared definitions
// Transaction types, status codes, packet layout constants and the magic table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrp_pkg;

   localparam int MaxDatagram = 4096;
   localparam int PosBits     = 13;
   localparam int PosSat      = 8191;
   localparam int MinLenOne   = 28;
   localparam int MinLenTwo   = 35;
   localparam int MinLenOneCk = 32;

   localparam logic [7:0] IdReplyOne  = 8'h06;
   localparam logic [7:0] IdReplyTwo  = 8'h08;
   localparam logic [7:0] AddrVersion = 8'd4;

   localparam logic [15:0] MtuLowerReset = 16'd576;
   localparam logic [15:0] MtuUpperReset = 16'd1492;

   localparam int CsrAddrBits = 3;

   typedef enum logic [0:0] {
      REG_MTU_LOWER = 1'b0,
      REG_MTU_UPPER = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_WRONG_ID  = 3'd2,
      STATUS_BAD_MAGIC = 3'd3,
      STATUS_TRUNCATED = 3'd4,
      STATUS_BAD_ADDR  = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       expect_second;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] server_guid;
      logic        security_on;
      logic        has_cookie;
      logic [31:0] cookie;
      logic [15:0] mtu_value;
      logic        mtu_in_range;
      logic [31:0] client_ip;
      logic [15:0] client_port;
   } rsp_type;

   typedef struct packed {
      logic [15:0] mtu_lower;
      logic [15:0] mtu_upper;
   } bounds_type;

   function automatic logic [7:0] magic_byte(input logic [3:0] idx);
      logic [7:0] val;
      case (idx)
         4'd0:    val = 8'h00;
         4'd1:    val = 8'hff;
         4'd2:    val = 8'hff;
         4'd3:    val = 8'h00;
         4'd4:    val = 8'hfe;
         4'd5:    val = 8'hfe;
         4'd6:    val = 8'hfe;
         4'd7:    val = 8'hfe;
         4'd8:    val = 8'hfd;
         4'd9:    val = 8'hfd;
         4'd10:   val = 8'hfd;
         4'd11:   val = 8'hfd;
         4'd12:   val = 8'h12;
         4'd13:   val = 8'h34;
         4'd14:   val = 8'h56;
         4'd15:   val = 8'h78;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* design/hrp_csr.sv */
// ---------------------------------------------------------------------------
// hrp_csr - configuration registers
// APB-style register file holding the MTU range bounds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrp_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [hrp_pkg::CsrAddrBits-1:0]  paddr,
   input  wire logic [31:0]                      pwdata,
   output logic      [31:0]                      prdata,
   output logic                                  pready,
   output hrp_pkg::bounds_type                   bounds
);

   logic [15:0] lower_ff, lower_in;
   logic [15:0] upper_ff, upper_in;
   logic        wr_en;
   hrp_pkg::reg_index_type idx;

   assign pready = 1'b1;
   assign idx    = hrp_pkg::reg_index_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (wr_en) begin
         case (idx)
            hrp_pkg::REG_MTU_LOWER: lower_in = pwdata[15:0];
            hrp_pkg::REG_MTU_UPPER: upper_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= hrp_pkg::MtuLowerReset;
         upper_ff <= hrp_pkg::MtuUpperReset;
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   always_comb begin
      case (idx)
         hrp_pkg::REG_MTU_LOWER: prdata = {16'd0, lower_ff};
         hrp_pkg::REG_MTU_UPPER: prdata = {16'd0, upper_ff};
         default:                prdata = 32'd0;
      endcase
   end

   assign bounds.mtu_lower = lower_ff;
   assign bounds.mtu_upper = upper_ff;

endmodule

`default_nettype wire

/* design/handshake_reply_parser.sv */
// ---------------------------------------------------------------------------
// handshake_reply_parser - open-connection reply parser
// Checks and decodes reply one / reply two datagrams presented a byte at a time.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one datagram byte per transaction with a last-byte flag and
//   the expected reply kind (taken from the first byte of each datagram).
//   Each byte is checked or captured at its position as it is accepted.
//   rsp_* carries one transaction per datagram, produced by its last byte:
//   a prioritised status code and the decoded fields (zero on error).
//   Latency: the result is valid in the cycle after the last byte is taken.
//   Throughput: one byte per cycle while req_ready is high, set by the single
//   decode stage between the packet state registers and the result register.
//   Stall: while a result waits and rsp_ready is low, req_ready is low;
//   taking the result in the same cycle frees the input at once.
//   Reset: synchronous, clears the packet state and the result valid, and
//   loads the MTU bounds with 576 and 1492. Bytes at positions 4096 and
//   beyond are ignored; the position counter saturates.
//   The MTU bounds are written through the APB-style port at 0x0 and 0x4.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module handshake_reply_parser (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire hrp_pkg::req_type                 req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output hrp_pkg::rsp_type                      rsp_payload,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [hrp_pkg::CsrAddrBits-1:0]  paddr,
   input  wire logic [31:0]                      pwdata,
   output logic      [31:0]                      prdata,
   output logic                                  pready
);

   localparam int PB = hrp_pkg::PosBits;

   hrp_pkg::bounds_type bounds;

   hrp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .bounds  (bounds)
   );

   logic [PB-1:0]       pos_ff, pos_in;
   logic                kind_ff, kind_in;
   hrp_pkg::status_type err_ff, err_in;
   logic [63:0]         guid_ff, guid_in;
   logic                sec_ff, sec_in;
   logic [31:0]         cookie_ff, cookie_in;
   logic [15:0]         mtu_ff, mtu_in;
   logic [31:0]         addr_ff, addr_in;
   logic [15:0]         port_ff, port_in;

   logic                rsp_valid_ff, rsp_valid_in;
   hrp_pkg::rsp_type    rsp_ff, rsp_in;

   logic                accept;
   logic                finish;
   logic [7:0]          b;
   logic [PB-1:0]       p;
   logic [PB:0]         len;
   hrp_pkg::status_type status;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign finish      = accept && req_payload.last_byte;
   assign b           = req_payload.data_byte;
   assign p           = pos_ff;
   assign len         = {1'b0, p} + (PB+1)'(1);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // per-byte field capture
   always_comb begin
      pos_in    = pos_ff;
      kind_in   = kind_ff;
      err_in    = err_ff;
      guid_in   = guid_ff;
      sec_in    = sec_ff;
      cookie_in = cookie_ff;
      mtu_in    = mtu_ff;
      addr_in   = addr_ff;
      port_in   = port_ff;
      if (accept) begin
         if (p == '0)
            kind_in = req_payload.expect_second;
         if (p < PB'(hrp_pkg::PosSat))
            pos_in = p + PB'(1);
         if (p < PB'(hrp_pkg::MaxDatagram)) begin
            if (p == '0) begin
               if (b != (kind_in ? hrp_pkg::IdReplyTwo : hrp_pkg::IdReplyOne)
                   && err_ff == hrp_pkg::STATUS_OK)
                  err_in = hrp_pkg::STATUS_WRONG_ID;
            end else if (p <= PB'(16)) begin
               if (b != hrp_pkg::magic_byte(p[3:0] - 4'd1)
                   && err_ff == hrp_pkg::STATUS_OK)
                  err_in = hrp_pkg::STATUS_BAD_MAGIC;
            end else if (p <= PB'(24)) begin
               guid_in = {guid_ff[55:0], b};
            end else if (!kind_ff) begin
               if (p == PB'(25)) begin
                  sec_in = (b != 8'd0);
               end else if (sec_ff) begin
                  if (p <= PB'(29))
                     cookie_in = {cookie_ff[23:0], b};
                  else if (p <= PB'(31))
                     mtu_in = {mtu_ff[7:0], b};
               end else if (p <= PB'(27)) begin
                  mtu_in = {mtu_ff[7:0], b};
               end
            end else begin
               if (p == PB'(25)) begin
                  if (b != hrp_pkg::AddrVersion && err_ff == hrp_pkg::STATUS_OK)
                     err_in = hrp_pkg::STATUS_BAD_ADDR;
               end else if (p <= PB'(29)) begin
                  addr_in = {addr_ff[23:0], ~b};
               end else if (p <= PB'(31)) begin
                  port_in = {port_ff[7:0], b};
               end else if (p <= PB'(33)) begin
                  mtu_in = {mtu_ff[7:0], b};
               end else if (p == PB'(34)) begin
                  sec_in = (b != 8'd0);
               end
            end
         end
      end
   end

   // result decode from the updated packet state
   always_comb begin
      if (len < (kind_in ? (PB+1)'(hrp_pkg::MinLenTwo) : (PB+1)'(hrp_pkg::MinLenOne)))
         status = hrp_pkg::STATUS_SHORT;
      else if (err_in != hrp_pkg::STATUS_OK)
         status = err_in;
      else if (!kind_in && sec_in && len < (PB+1)'(hrp_pkg::MinLenOneCk))
         status = hrp_pkg::STATUS_TRUNCATED;
      else
         status = hrp_pkg::STATUS_OK;

      rsp_in        = '0;
      rsp_in.status = status;
      if (status == hrp_pkg::STATUS_OK) begin
         rsp_in.server_guid  = guid_in;
         rsp_in.security_on  = sec_in;
         rsp_in.mtu_value    = mtu_in;
         rsp_in.mtu_in_range = (mtu_in >= bounds.mtu_lower) && (mtu_in <= bounds.mtu_upper);
         if (!kind_in) begin
            rsp_in.has_cookie = sec_in;
            rsp_in.cookie     = sec_in ? cookie_in : 32'd0;
         end else begin
            rsp_in.client_ip   = addr_in;
            rsp_in.client_port = port_in;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready)
         rsp_valid_in = 1'b0;
      if (finish)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         pos_ff    <= '0;
         kind_ff   <= 1'b0;
         err_ff    <= hrp_pkg::STATUS_OK;
         guid_ff   <= '0;
         sec_ff    <= 1'b0;
         cookie_ff <= '0;
         mtu_ff    <= '0;
         addr_ff   <= '0;
         port_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         kind_ff   <= kind_in;
         err_ff    <= err_in;
         guid_ff   <= guid_in;
         sec_ff    <= sec_in;
         cookie_ff <= cookie_in;
         mtu_ff    <= mtu_in;
         addr_ff   <= addr_in;
         port_ff   <= port_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (finish)
         rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// tb - handshake reply parser testbench
// Feeds reply one / reply two datagrams a byte at a time, directed corner cases
// first, then mostly well-formed replies with random content mixed with
// corrupted, short and noise datagrams. Each accepted byte goes through a
// cycle-free model of the parser. Each reply transaction is checked field by
// field against the oldest predicted one. MTU bounds are rewritten between
// phases, extremes included. Both sides idle in random bursts, and the
// receiver stalls for one long stretch so that the input backs up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int FLAW_ID      = 1;
   localparam int FLAW_MAGIC   = 2;
   localparam int FLAW_VERSION = 4;
   localparam int FLAW_NOISE   = 8;

   localparam int SEC_OFF = 0;
   localparam int SEC_ON  = 1;
   localparam int SEC_ANY = 2;

   localparam int FILL_RANDOM = -1;

   localparam int PhaseBytes  = 125;
   localparam int LongHold    = 300;
   localparam int QuietLimit  = 3000;

   localparam logic [127:0] MagicPattern = 128'h00ffff00_fefefefe_fdfdfdfd_12345678;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   hrp_pkg::req_type                req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   hrp_pkg::rsp_type                rsp_payload;
   logic                            psel        = 1'b0;
   logic                            penable     = 1'b0;
   logic                            pwrite      = 1'b0;
   logic [hrp_pkg::CsrAddrBits-1:0] paddr       = '0;
   logic [31:0]                     pwdata      = '0;
   logic [31:0]                     prdata;
   logic                            pready;

   hrp_pkg::req_type byte_q [$];
   hrp_pkg::rsp_type reply_q [$];
   hrp_pkg::rsp_type reply_want;

   // parser model state
   logic [hrp_pkg::PosBits-1:0] byte_pos;
   logic                        reply_two;
   hrp_pkg::status_type         first_error;
   logic [63:0]                 guid_acc;
   logic                        secure_acc;
   logic [31:0]                 cookie_acc;
   logic [15:0]                 mtu_acc;
   logic [31:0]                 addr_acc;
   logic [15:0]                 port_acc;
   logic [15:0]                 mtu_lo = hrp_pkg::MtuLowerReset;
   logic [15:0]                 mtu_hi = hrp_pkg::MtuUpperReset;

   int   send_gap          = 0;
   int   recv_gap          = 0;
   int   idle_odds         = 6;
   logic calm              = 1'b0;
   logic long_hold_pending = 1'b0;
   int   quiet_cycles      = 0;
   int   mismatches        = 0;
   int   sent_count;

   handshake_reply_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #10 clock = ~clock;

   task automatic clear_packet_state;
      byte_pos    = '0;
      reply_two   = 1'b0;
      first_error = hrp_pkg::STATUS_OK;
      guid_acc    = '0;
      secure_acc  = 1'b0;
      cookie_acc  = '0;
      mtu_acc     = '0;
      addr_acc    = '0;
      port_acc    = '0;
   endtask

   task automatic parse_byte(input hrp_pkg::req_type item);
      logic [hrp_pkg::PosBits-1:0] p;
      logic [7:0]                  b;
      int                          len;
      hrp_pkg::status_type         st;
      hrp_pkg::rsp_type            r;
      p = byte_pos;
      b = item.data_byte;
      if (p == 0) reply_two = item.expect_second;
      if (p < hrp_pkg::MaxDatagram) begin
         if (p == 0) begin
            if (b != (reply_two ? hrp_pkg::IdReplyTwo : hrp_pkg::IdReplyOne)
                && first_error == hrp_pkg::STATUS_OK)
               first_error = hrp_pkg::STATUS_WRONG_ID;
         end else if (p <= 16) begin
            if (b != MagicPattern[8 * (16 - int'(p)) +: 8]
                && first_error == hrp_pkg::STATUS_OK)
               first_error = hrp_pkg::STATUS_BAD_MAGIC;
         end else if (p <= 24) begin
            guid_acc = {guid_acc[55:0], b};
         end else if (!reply_two) begin
            if (p == 25) begin
               secure_acc = (b != 8'h00);
            end else if (secure_acc) begin
               if (p <= 29) cookie_acc = {cookie_acc[23:0], b};
               else if (p <= 31) mtu_acc = {mtu_acc[7:0], b};
            end else if (p <= 27) begin
               mtu_acc = {mtu_acc[7:0], b};
            end
         end else begin
            if (p == 25) begin
               if (b != hrp_pkg::AddrVersion && first_error == hrp_pkg::STATUS_OK)
                  first_error = hrp_pkg::STATUS_BAD_ADDR;
            end else if (p <= 29) begin
               addr_acc = {addr_acc[23:0], ~b};
            end else if (p <= 31) begin
               port_acc = {port_acc[7:0], b};
            end else if (p <= 33) begin
               mtu_acc = {mtu_acc[7:0], b};
            end else if (p == 34) begin
               secure_acc = (b != 8'h00);
            end
         end
      end
      if (p < hrp_pkg::PosSat) byte_pos = p + 1'b1;
      if (item.last_byte) begin
         len = int'(p) + 1;
         if (len < (reply_two ? hrp_pkg::MinLenTwo : hrp_pkg::MinLenOne))
            st = hrp_pkg::STATUS_SHORT;
         else if (first_error != hrp_pkg::STATUS_OK)
            st = first_error;
         else if (!reply_two && secure_acc && len < hrp_pkg::MinLenOneCk)
            st = hrp_pkg::STATUS_TRUNCATED;
         else
            st = hrp_pkg::STATUS_OK;
         r = '0;
         r.status = st;
         if (st == hrp_pkg::STATUS_OK) begin
            r.server_guid  = guid_acc;
            r.security_on  = secure_acc;
            r.mtu_value    = mtu_acc;
            r.mtu_in_range = (mtu_acc >= mtu_lo) && (mtu_acc <= mtu_hi);
            if (!reply_two) begin
               r.has_cookie = secure_acc;
               r.cookie     = secure_acc ? cookie_acc : 32'h0;
            end else begin
               r.client_ip   = addr_acc;
               r.client_port = port_acc;
            end
         end
         reply_q = {reply_q, r};
         clear_packet_state();
      end
   endtask

   function automatic logic [7:0] field_byte(input int fill);
      return (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
   endfunction

   function automatic logic [15:0] pick_mtu;
      case ($urandom_range(0, 5))
         0:       return mtu_lo;
         1:       return mtu_hi;
         2:       return mtu_lo - 16'd1;
         3:       return mtu_hi + 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // builds one reply, applies the requested flaws and queues it cut or padded by extra bytes
   task automatic queue_datagram(input logic second, input int flaws, input int sec_mode,
                                 input int extra, input int fill, output int count);
      logic [7:0]       pkt [$];
      logic [7:0]       secb;
      logic [15:0]      mtu;
      int               i;
      int               len;
      hrp_pkg::req_type item;
      case (sec_mode)
         SEC_OFF: secb = 8'h00;
         SEC_ON:  secb = (fill > 0) ? 8'(fill) : 8'($urandom_range(1, 255));
         default: secb = $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'h00;
      endcase
      mtu = (fill < 0) ? pick_mtu() : {8'(fill), 8'(fill)};
      pkt = {pkt, (second ? hrp_pkg::IdReplyTwo : hrp_pkg::IdReplyOne)};
      for (i = 1; i <= 16; i++) pkt = {pkt, MagicPattern[8 * (16 - i) +: 8]};
      for (i = 0; i < 8; i++) pkt = {pkt, field_byte(fill)};
      if (!second) begin
         pkt = {pkt, secb};
         if (secb != 8'h00) for (i = 0; i < 4; i++) pkt = {pkt, field_byte(fill)};
         pkt = {pkt, mtu[15:8]};
         pkt = {pkt, mtu[7:0]};
      end else begin
         pkt = {pkt, hrp_pkg::AddrVersion};
         for (i = 0; i < 6; i++) pkt = {pkt, field_byte(fill)};
         pkt = {pkt, mtu[15:8]};
         pkt = {pkt, mtu[7:0]};
         pkt = {pkt, secb};
      end
      len = pkt.size() + extra;
      if (len < 1) len = 1;
      while (pkt.size() < len) pkt = {pkt, field_byte(FILL_RANDOM)};
      if (flaws & FLAW_NOISE)
         for (i = 0; i < pkt.size(); i++) pkt[i] = field_byte(FILL_RANDOM);
      if (flaws & FLAW_ID) pkt[0] ^= 8'($urandom_range(1, 255));
      if (flaws & FLAW_MAGIC) pkt[$urandom_range(1, 16)] ^= 8'($urandom_range(1, 255));
      if (flaws & FLAW_VERSION) pkt[25] ^= 8'($urandom_range(1, 255));
      for (i = 0; i < len; i++) begin
         item.data_byte     = pkt[i];
         item.last_byte     = (i == len - 1);
         item.expect_second = (i == 0) ? second : 1'($urandom_range(0, 1));
         byte_q = {byte_q, item};
      end
      count = len;
   endtask

   task automatic queue_random_datagram(output int count);
      logic second;
      int   pick;
      int   flaws;
      int   extra;
      second = 1'($urandom_range(0, 1));
      pick   = $urandom_range(0, 99);
      flaws  = 0;
      extra  = 0;
      if (pick < 62) extra = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
      else if (pick < 70) flaws = FLAW_ID;
      else if (pick < 76) flaws = FLAW_MAGIC;
      else if (pick < 81) flaws = FLAW_VERSION;
      else if (pick < 84) flaws = $urandom_range(1, 7);
      else if (pick < 90) extra = -int'($urandom_range(1, 4));
      else if (pick < 95) extra = -int'($urandom_range(5, 34));
      else begin
         flaws = FLAW_NOISE;
         extra = int'($urandom_range(0, 8)) - 20;
      end
      queue_datagram(second, flaws, SEC_ANY, extra, FILL_RANDOM, count);
   endtask

   task automatic queue_random_bytes(input int budget);
      int total;
      int n;
      total = 0;
      while (total < budget) begin
         queue_random_datagram(n);
         total += n;
      end
   endtask

   task automatic csr_write(input hrp_pkg::reg_index_type idx, input logic [15:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == hrp_pkg::REG_MTU_LOWER) mtu_lo = value;
      else mtu_hi = value;
   endtask

   task automatic set_bounds(input logic [15:0] lower, input logic [15:0] upper);
      csr_write(hrp_pkg::REG_MTU_LOWER, lower);
      csr_write(hrp_pkg::REG_MTU_UPPER, upper);
      @(negedge clock);
   endtask

   task automatic wait_drained;
      while (byte_q.size() != 0 || req_valid || reply_q.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
         clear_packet_state();
      end else begin
         if (req_valid && req_ready) parse_byte(req_payload);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(1, idle_odds) == 1) begin
               send_gap  <= $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
               req_payload <= byte_q.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reply_q.size() == 0) begin
               $error("reply transaction with nothing expected");
               mismatches++;
            end else begin
               reply_want = reply_q.pop_front();
               check_field("status", reply_want.status, rsp_payload.status);
               check_field("server_guid", reply_want.server_guid, rsp_payload.server_guid);
               check_field("security_on", reply_want.security_on, rsp_payload.security_on);
               check_field("has_cookie", reply_want.has_cookie, rsp_payload.has_cookie);
               check_field("cookie", reply_want.cookie, rsp_payload.cookie);
               check_field("mtu_value", reply_want.mtu_value, rsp_payload.mtu_value);
               check_field("mtu_in_range", reply_want.mtu_in_range, rsp_payload.mtu_in_range);
               check_field("client_ip", reply_want.client_ip, rsp_payload.client_ip);
               check_field("client_port", reply_want.client_port, rsp_payload.client_port);
            end
         end
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            recv_gap  <= LongHold;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(1, idle_odds) == 1) begin
            recv_gap  <= $urandom_range(0, 14);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QuietLimit) begin
            $display("status: fail");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed cases under the reset bounds
      queue_datagram(1'b0, 0, SEC_OFF, 0, FILL_RANDOM, sent_count);
      queue_datagram(1'b0, 0, SEC_ON, 0, 8'hff, sent_count);
      queue_datagram(1'b0, 0, SEC_OFF, 0, 8'h00, sent_count);
      queue_datagram(1'b1, 0, SEC_OFF, 0, 8'h00, sent_count);
      queue_datagram(1'b1, 0, SEC_ON, 0, 8'hff, sent_count);
      queue_datagram(1'b0, 0, SEC_OFF, -1, FILL_RANDOM, sent_count);
      queue_datagram(1'b1, 0, SEC_ON, -1, FILL_RANDOM, sent_count);
      queue_datagram(1'b0, 0, SEC_OFF, -100, FILL_RANDOM, sent_count);
      queue_datagram(1'b1, 0, SEC_OFF, -100, FILL_RANDOM, sent_count);
      queue_datagram(1'b0, FLAW_ID, SEC_ANY, 0, FILL_RANDOM, sent_count);
      queue_datagram(1'b1, FLAW_ID, SEC_ANY, 0, FILL_RANDOM, sent_count);
      queue_datagram(1'b0, FLAW_MAGIC, SEC_ANY, 0, FILL_RANDOM, sent_count);
      queue_datagram(1'b1, FLAW_MAGIC, SEC_ANY, 0, FILL_RANDOM, sent_count);
      queue_datagram(1'b1, FLAW_VERSION, SEC_ANY, 0, FILL_RANDOM, sent_count);
      queue_datagram(1'b0, FLAW_ID | FLAW_MAGIC, SEC_OFF, 0, FILL_RANDOM, sent_count);
      queue_datagram(1'b1, FLAW_MAGIC | FLAW_VERSION, SEC_ON, 0, FILL_RANDOM, sent_count);
      queue_datagram(1'b0, FLAW_ID, SEC_OFF, -3, FILL_RANDOM, sent_count);
      queue_datagram(1'b0, 0, SEC_ON, -2, FILL_RANDOM, sent_count);
      queue_datagram(1'b0, 0, SEC_ON, -4, FILL_RANDOM, sent_count);
      queue_datagram(1'b0, 0, SEC_ON, -5, FILL_RANDOM, sent_count);
      queue_datagram(1'b0, FLAW_MAGIC, SEC_ON, -2, FILL_RANDOM, sent_count);
      queue_datagram(1'b1, 0, SEC_ANY, 6, FILL_RANDOM, sent_count);
      wait_drained();

      idle_odds = 4;
      @(negedge clock);
      queue_random_bytes(PhaseBytes);
      wait_drained();

      // widest window, then a long receiver stall with one-byte datagrams queued
      set_bounds(16'h0000, 16'hffff);
      idle_odds = 12;
      long_hold_pending = 1'b1;
      repeat (30) queue_datagram(1'($urandom_range(0, 1)), FLAW_NOISE, SEC_ANY, -100,
                                 FILL_RANDOM, sent_count);
      queue_random_bytes(PhaseBytes);
      wait_drained();

      // crossed bounds
      set_bounds(16'hffff, 16'h0000);
      idle_odds = 3;
      queue_random_bytes(PhaseBytes);
      wait_drained();

      set_bounds(16'd1200, 16'd1200);
      idle_odds = 8;
      queue_random_bytes(PhaseBytes);
      wait_drained();

      set_bounds(16'($urandom_range(500, 1000)), 16'($urandom_range(1000, 1600)));
      calm = 1'b1;
      queue_random_bytes(PhaseBytes);
      wait_drained();

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
